// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the list sequencer. Every check is clocked on clk_i and
// is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define SLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be seen at a rising edge outside reset.
`define SLE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/sle_pkg.sv -----
package sle_pkg;

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_GET    = 3'd1,
    KIND_LOCATE = 3'd2,
    KIND_INSERT = 3'd3,
    KIND_DELETE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_LOCATE,
    S_INSERT,
    S_INS_PUT,
    S_DELETE,
    S_FINISH
  } state_e;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic               done;
    logic               status;
    logic signed [31:0] element;
    logic [7:0]         found_at;
    logic [7:0]         count;
  } result_t;

endpackage

// ----- hw/rtl/sle_store.sv -----
module sle_store #(
  parameter int unsigned CAPACITY = 128,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [CAPACITY];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data is registered; the port keeps its last word while not reading.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sle_seq.sv -----
`include "assert_macros.svh"

module sle_seq import sle_pkg::*; #(
  parameter int unsigned CAPACITY = 128,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned LW = $clog2(CAPACITY + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_i,
  input  logic [2:0]         kind_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] value_i,
  input  logic               out_free_i,
  output logic               busy_o,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output logic [31:0]        mem_wdata_o,
  output logic               mem_re_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  logic [31:0]        mem_rdata_i,
  output result_t            res_o
);

  // Compare width: wide enough for both the position and the length plus one.
  localparam int unsigned CW = ((LW > 8) ? LW : 8) + 1;

  state_e        state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] tgt_q, tgt_d;
  logic [31:0]   val_q, val_d;
  logic          status_q, status_d;
  logic [31:0]   element_q, element_d;
  logic [7:0]    found_q, found_d;
  logic          done_w;
  logic          walk_w;

  logic [CW-1:0] pos_w, len_w, pos_m1_w, len_m1_w, idx_next_w, len_ext_w;
  logic          pos_ok_rd, pos_ok_ins;

  assign pos_w      = CW'(position_i);
  assign len_w      = CW'(len_q);
  assign pos_m1_w   = pos_w - CW'(1);
  assign len_m1_w   = len_w - CW'(1);
  assign idx_next_w = CW'(idx_q) + CW'(1);
  assign len_ext_w  = CW'(len_q);

  assign pos_ok_rd  = (pos_w != '0) && (pos_w <= len_w);
  assign pos_ok_ins = (pos_w != '0) && (pos_w <= len_w + CW'(1)) &&
                      (len_w < CW'(CAPACITY));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    tgt_q     <= tgt_d;
    val_q     <= val_d;
    status_q  <= status_d;
    element_q <= element_d;
    found_q   <= found_d;
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    idx_d       = idx_q;
    tgt_d       = tgt_q;
    val_d       = val_q;
    status_d    = status_q;
    element_d   = element_q;
    found_d     = found_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;
    done_w      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i) begin
          val_d     = value_i;
          tgt_d     = pos_m1_w[AW-1:0];
          status_d  = STATUS_OK;
          element_d = '0;
          found_d   = '0;
          state_d   = S_FINISH;
          case (kind_i)
            KIND_CLEAR: begin
              len_d = '0;
            end
            KIND_GET: begin
              if (pos_ok_rd) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = pos_m1_w[AW-1:0];
                state_d     = S_GET;
              end else begin
                status_d = STATUS_ERR;
              end
            end
            KIND_LOCATE: begin
              if (len_q != '0) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                idx_d       = '0;
                state_d     = S_LOCATE;
              end
            end
            KIND_INSERT: begin
              if (!pos_ok_ins) begin
                status_d = STATUS_ERR;
              end else if (pos_w <= len_w) begin
                // Entries from the tail down to the target move up one place.
                mem_re_o    = 1'b1;
                mem_raddr_o = len_m1_w[AW-1:0];
                idx_d       = len_m1_w[AW-1:0];
                state_d     = S_INSERT;
              end else begin
                state_d = S_INS_PUT;
              end
            end
            KIND_DELETE: begin
              if (pos_ok_rd) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = pos_m1_w[AW-1:0];
                idx_d       = pos_m1_w[AW-1:0];
                state_d     = S_DELETE;
              end else begin
                status_d = STATUS_ERR;
              end
            end
            default: begin
              status_d = STATUS_ERR;
            end
          endcase
        end
      end

      S_GET: begin
        element_d = mem_rdata_i;
        state_d   = S_FINISH;
      end

      // The next entry is fetched while the current one is compared.
      S_LOCATE: begin
        if (mem_rdata_i == val_q) begin
          found_d = idx_next_w[7:0];
          state_d = S_FINISH;
        end else if (idx_next_w == len_w) begin
          state_d = S_FINISH;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_next_w[AW-1:0];
          idx_d       = idx_next_w[AW-1:0];
        end
      end

      S_INSERT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q + AW'(1);
        mem_wdata_o = mem_rdata_i;
        if (idx_q == tgt_q) begin
          state_d = S_INS_PUT;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q - AW'(1);
          idx_d       = idx_q - AW'(1);
        end
      end

      S_INS_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = tgt_q;
        mem_wdata_o = val_q;
        len_d       = len_q + LW'(1);
        state_d     = S_FINISH;
      end

      // The first word read is the removed element; later words move down.
      S_DELETE: begin
        if (idx_q == tgt_q) begin
          element_d = mem_rdata_i;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_q - AW'(1);
          mem_wdata_o = mem_rdata_i;
        end
        if (idx_next_w == len_w) begin
          len_d   = len_q - LW'(1);
          state_d = S_FINISH;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_next_w[AW-1:0];
          idx_d       = idx_next_w[AW-1:0];
        end
      end

      S_FINISH: begin
        if (out_free_i) begin
          done_w  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o         = (state_q != S_IDLE);
  assign walk_w         = (state_q == S_LOCATE) || (state_q == S_DELETE);
  assign res_o.done     = done_w;
  assign res_o.status   = status_q;
  assign res_o.element  = element_q;
  assign res_o.found_at = found_q;
  assign res_o.count    = len_ext_w[7:0];

  `SLE_ASSERT(a_len_bound, CW'(len_q) <= CW'(CAPACITY), "list length beyond capacity")
  `SLE_ASSERT(a_req_busy, req_i |=> busy_o, "request taken but sequencer stayed idle")
  `SLE_NEVER(a_done_blocked, res_o.done && !out_free_i, "result issued into a full output")
  `SLE_ASSERT(a_walk_in_list, walk_w |-> CW'(idx_q) < len_w, "walk index outside the list")

endmodule

// ----- hw/rtl/sequential_list_engine.sv -----
// Channel | Direction | Handshake             | Payload
// request | in        | in_valid_i/in_stall_o | kind_i, position_i, value_i
// result  | out       | out_valid_o/out_stall_i | status_o, element_o, found_at_o, count_o
//
// One request is worked at a time; the store has one read and one write port and the
// sequencer moves or compares one entry per cycle.
// Reset empties the list at once; the store itself is not cleared and needs no pass.
// A finished result waits in the output register while the next request is taken; the
// sequencer only holds in its final state when that register is still stalled.
module sequential_list_engine import sle_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic signed [31:0] element_o,
  output logic [7:0]         found_at_o,
  output logic [7:0]         count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic          busy;
  logic          in_xfer;
  logic          out_free;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;
  result_t       res;

  logic               out_valid_q, out_valid_d;
  logic               status_q;
  logic signed [31:0] element_q;
  logic [7:0]         found_q;
  logic [7:0]         count_q;

  assign in_stall_o = busy;
  assign in_xfer    = in_valid_i && !busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  sle_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_xfer),
    .kind_i      (kind_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_free_i  (out_free),
    .busy_o      (busy),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_o       (res)
  );

  sle_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done) begin
      status_q  <= res.status;
      element_q <= res.element;
      found_q   <= res.found_at;
      count_q   <= res.count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign found_at_o  = found_q;
  assign count_o     = count_q;

endmodule
